// ===== sv/sfp_pkg.sv =====
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared constants and types for the serial frame parser.
// ----------------------------------------------------------------------------
package sfp_pkg;

	localparam int MAX_BODY  = 64;
	localparam int BODY_AW   = $clog2(MAX_BODY);
	localparam int NUM_BANKS = 2;
	localparam int BANK_W    = $clog2(NUM_BANKS);
	localparam int RAM_DEPTH = MAX_BODY * NUM_BANKS;
	localparam int RAM_AW    = $clog2(RAM_DEPTH);
	localparam int QCNT_W    = $clog2(NUM_BANKS + 1);

	localparam logic [7:0] REG_SYNC_HIGH = 8'd0;
	localparam logic [7:0] REG_SYNC_LOW  = 8'd1;

	localparam logic [7:0] SYNC_HIGH_RST = 8'hAA;
	localparam logic [7:0] SYNC_LOW_RST  = 8'h55;

	// one verified frame waiting in a buffer bank
	typedef struct packed {
		logic [BANK_W-1:0]  bank;
		logic [BODY_AW-1:0] len;
	} desc_t;

	typedef struct packed {
		logic              en;
		logic [RAM_AW-1:0] addr;
		logic [7:0]        data;
	} ram_wr_t;

endpackage

// ===== sv/sfp_ram.sv =====
// ----------------------------------------------------------------------------
// sfp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/sfp_front.sv =====
// ----------------------------------------------------------------------------
// sfp_front
// Sync hunt, length check, body capture and checksum test.
// ----------------------------------------------------------------------------
module sfp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [7:0]          cfg_index,
	input  logic [7:0]          cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          rx_byte,
	input  logic                q_full,
	output logic                push,
	output sfp_pkg::desc_t      push_desc,
	output sfp_pkg::ram_wr_t    ram_wr
);
	import sfp_pkg::*;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_SYNC2,
		PH_LEN,
		PH_BODY
	} phase_t;

	phase_t             phase_q;
	logic [7:0]         sync_high_q;
	logic [7:0]         sync_low_q;
	logic [BODY_AW-1:0] len_q;
	logic [BODY_AW-1:0] fill_q;
	logic [7:0]         sum_q;
	logic [BANK_W-1:0]  wr_bank_q;

	logic accept;
	logic in_body;
	logic len_ok;

	// a body may only be captured into a bank that is not awaiting emission
	assign in_ready = !(phase_q == PH_BODY && q_full);
	assign accept   = in_valid && in_ready;
	assign in_body  = (phase_q == PH_BODY) && (fill_q != len_q);
	assign len_ok   = (rx_byte != 8'd0) && ({1'b0, rx_byte} < 9'(MAX_BODY));

	assign ram_wr.en   = accept && in_body;
	assign ram_wr.addr = {wr_bank_q, fill_q};
	assign ram_wr.data = rx_byte;

	assign push           = accept && (phase_q == PH_BODY) && !in_body && (sum_q == rx_byte);
	assign push_desc.bank = wr_bank_q;
	assign push_desc.len  = len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			sync_high_q <= SYNC_HIGH_RST;
			sync_low_q  <= SYNC_LOW_RST;
			len_q       <= '0;
			fill_q      <= '0;
			sum_q       <= '0;
			wr_bank_q   <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_SYNC_HIGH) begin
					sync_high_q <= cfg_data;
				end else if (cfg_index == REG_SYNC_LOW) begin
					sync_low_q <= cfg_data;
				end
			end
			if (accept) begin
				case (phase_q)
					PH_HUNT: begin
						if (rx_byte == sync_high_q) begin
							phase_q <= PH_SYNC2;
						end
					end
					PH_SYNC2: begin
						phase_q <= (rx_byte == sync_low_q) ? PH_LEN : PH_HUNT;
					end
					PH_LEN: begin
						if (len_ok) begin
							len_q   <= rx_byte[BODY_AW-1:0];
							fill_q  <= '0;
							sum_q   <= '0;
							phase_q <= PH_BODY;
						end else begin
							phase_q <= PH_HUNT;
						end
					end
					PH_BODY: begin
						if (in_body) begin
							sum_q  <= sum_q + rx_byte;
							fill_q <= fill_q + 1'b1;
						end else begin
							// checksum beat: hand the bank over only if it matched
							if (sum_q == rx_byte) begin
								wr_bank_q <= wr_bank_q + 1'b1;
							end
							phase_q <= PH_HUNT;
						end
					end
					default: phase_q <= PH_HUNT;
				endcase
			end
		end
	end

endmodule

// ===== sv/sfp_queue.sv =====
// ----------------------------------------------------------------------------
// sfp_queue
// Small descriptor queue of verified frames between front and back.
// ----------------------------------------------------------------------------
module sfp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sfp_pkg::desc_t push_desc,
	input  logic           pop,
	output logic           not_empty,
	output logic           full,
	output sfp_pkg::desc_t head
);
	import sfp_pkg::*;

	desc_t             ent_q [NUM_BANKS];
	logic [BANK_W-1:0] wr_ptr_q;
	logic [BANK_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign not_empty = (count_q != '0);
	assign full      = (count_q == QCNT_W'(NUM_BANKS));
	assign head      = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== sv/sfp_back.sv =====
// ----------------------------------------------------------------------------
// sfp_back
// Reads verified frames out of their bank, one beat per cycle while out_ready allows.
// ----------------------------------------------------------------------------
module sfp_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        not_empty,
	input  sfp_pkg::desc_t              head,
	output logic                        pop,
	output logic                        re,
	output logic [sfp_pkg::RAM_AW-1:0]  raddr,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [sfp_pkg::BODY_AW-1:0] out_pos,
	output logic                        out_last
);
	import sfp_pkg::*;

	logic [BODY_AW-1:0] idx_q;
	logic               valid_q;
	logic [BODY_AW-1:0] pos_q;
	logic               last_q;
	logic               advance;
	logic               is_last;

	// RAM read register doubles as the output data register
	assign advance   = !valid_q || out_ready;
	assign re        = advance && not_empty;
	assign raddr     = {head.bank, idx_q};
	assign is_last   = (idx_q == head.len - 1'b1);
	assign pop       = re && is_last;
	assign out_valid = valid_q;
	assign out_pos   = pos_q;
	assign out_last  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
			pos_q   <= '0;
			last_q  <= 1'b0;
		end else if (advance) begin
			valid_q <= not_empty;
			if (not_empty) begin
				pos_q  <= idx_q;
				last_q <= is_last;
				idx_q  <= is_last ? '0 : idx_q + 1'b1;
			end
		end
	end

endmodule

// ===== sv/serial_frame_parser.sv =====
// ----------------------------------------------------------------------------
// serial_frame_parser
// Sync / length / checksum frame parser for a received byte stream.
// ----------------------------------------------------------------------------
// Slave stream: one received byte per beat in s_tdata. The front end hunts
// for the two sync bytes (registers 0 and 1 on the cfg port), reads a length
// of 1..63, captures the body into one of two RAM banks and tests the 8-bit
// checksum. A matching frame is queued; a bad one is dropped without output.
// Master stream: one body byte per beat, its position in the frame alongside,
// tlast on the final byte.
// Input takes one byte per cycle. It stalls only on body and checksum bytes
// while both banks hold verified frames not yet fully read out.
// With the back end idle, a taken checksum beat is registered in the queue,
// then the first body beat is read into the RAM read register; the rest follow
// one per cycle while m_tready stays high. The RAM read register is the output
// register, so a stalled beat holds and the next read waits.
// Reset returns to sync hunting, empties the queue and restores the sync
// registers to 0xAA and 0x55.
// ----------------------------------------------------------------------------
module serial_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] body_byte, [13:8] body_position, [15:14] zero
	output logic        m_tlast    // body_last
);
	import sfp_pkg::*;

	logic               push;
	desc_t              push_desc;
	ram_wr_t            ram_wr;
	logic               q_full;
	logic               q_not_empty;
	desc_t              q_head;
	logic               pop;
	logic               re;
	logic [RAM_AW-1:0]  raddr;
	logic [7:0]         rdata;
	logic [BODY_AW-1:0] out_pos;

	sfp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.rx_byte   (s_tdata),
		.q_full    (q_full),
		.push      (push),
		.push_desc (push_desc),
		.ram_wr    (ram_wr)
	);

	sfp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.not_empty (q_not_empty),
		.full      (q_full),
		.head      (q_head)
	);

	sfp_ram #(
		.WIDTH (8),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_wr.en),
		.waddr (ram_wr.addr),
		.wdata (ram_wr.data),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	sfp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (q_not_empty),
		.head      (q_head),
		.pop       (pop),
		.re        (re),
		.raddr     (raddr),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_pos   (out_pos),
		.out_last  (m_tlast)
	);

	assign m_tdata = {2'b00, out_pos, rdata};

endmodule

// ===== sv/sfp_checker.sv =====
// ----------------------------------------------------------------------------
// sfp_checker
// Port-level checks on the output stream of the frame parser.
// ----------------------------------------------------------------------------
module sfp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tlast
);

	logic [5:0] exp_pos_q;
	logic       m_beat;

	assign m_beat = m_tvalid && m_tready;

	// positions within a frame count up from zero, restarting after tlast
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_pos_q <= '0;
		end else if (m_beat) begin
			exp_pos_q <= m_tlast ? 6'd0 : m_tdata[13:8] + 6'd1;
		end
	end

	a_idle_in_reset: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("m_tvalid high during reset");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled beat changed");

	a_pos_seq: assert property (@(posedge clk) disable iff (!arst_n)
		m_beat |-> m_tdata[13:8] == exp_pos_q)
		else $error("body position out of sequence");

	a_frame_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_beat && m_tdata[13:8] == 6'd62 |-> m_tlast)
		else $error("frame longer than 63 bytes");

endmodule

bind serial_frame_parser sfp_checker u_sfp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

// ===== sim/serial_frame_parser_tb.sv =====
// ----------------------------------------------------------------------------
// serial_frame_parser_tb
// Self-checking bench for the sync / length / checksum frame parser.
// ----------------------------------------------------------------------------
// A frame predictor follows every accepted rx byte and queues the body beats
// that a verified frame must produce; each output beat is checked against the
// oldest one. The stream opens with hand-made frames (smallest length, bad
// sync, bad lengths, bad checksum, overflowing sum), then runs random phases
// under several sync settings: mostly well-formed frames with random bodies,
// mixed with broken frames and line noise. Both sides stall at random, and
// once the receiver holds off long enough to fill both buffer banks.
// ----------------------------------------------------------------------------
module serial_frame_parser_tb;
	import sfp_pkg::*;

	localparam logic [7:0] REG_UNUSED_LO = 8'd2;
	localparam logic [7:0] REG_UNUSED_HI = 8'hFF;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_LIMIT  = 4000;
	localparam int TAIL_CYCLES  = 8;
	localparam int PHASE_ITEMS  = 75;
	localparam longint RUN_LIMIT = 64'd4_000_000;

	typedef enum logic [1:0] {
		HUNT_HIGH,
		HUNT_LOW,
		READ_LEN,
		TAKE_BODY
	} parse_phase_t;

	typedef struct {
		logic [7:0] data;
		logic [5:0] pos;
		logic       is_last;
	} body_beat_t;

	class frame_scoreboard;
		logic [7:0]   sync_high;
		logic [7:0]   sync_low;
		parse_phase_t ph;
		int           frame_length;
		int           fill_count;
		logic [7:0]   running_sum;
		logic [7:0]   body_store [MAX_BODY];
		body_beat_t   expected_beats [$];
		int           errors;

		function new();
			sync_high    = SYNC_HIGH_RST;
			sync_low     = SYNC_LOW_RST;
			ph           = HUNT_HIGH;
			frame_length = 0;
			fill_count   = 0;
			running_sum  = 8'h00;
			errors       = 0;
			foreach (body_store[i]) body_store[i] = 8'h00;
		endfunction

		function void write_reg(logic [7:0] idx, logic [7:0] val);
			case (idx)
				REG_SYNC_HIGH: sync_high = val;
				REG_SYNC_LOW:  sync_low  = val;
				default: ;
			endcase
		endfunction

		function void note_rx_byte(logic [7:0] b);
			body_beat_t e;
			case (ph)
				HUNT_HIGH: begin
					if (b == sync_high) ph = HUNT_LOW;
				end
				HUNT_LOW: begin
					// a wrong second byte is not retried as a first sync byte
					ph = (b == sync_low) ? READ_LEN : HUNT_HIGH;
				end
				READ_LEN: begin
					if (b == 8'd0 || int'(b) >= MAX_BODY) begin
						ph = HUNT_HIGH;
					end else begin
						frame_length = int'(b);
						fill_count   = 0;
						running_sum  = 8'h00;
						ph           = TAKE_BODY;
					end
				end
				TAKE_BODY: begin
					if (fill_count < MAX_BODY) body_store[fill_count] = b;
					if (fill_count < frame_length) begin
						running_sum = running_sum + b;
						fill_count++;
					end else begin
						// checksum byte: emit the whole body on a match
						fill_count++;
						if (running_sum == b) begin
							for (int i = 0; i < frame_length && i < MAX_BODY; i++) begin
								e.data    = body_store[i];
								e.pos     = i[5:0];
								e.is_last = (i + 1 == frame_length);
								expected_beats.push_back(e);
							end
						end
						ph = HUNT_HIGH;
					end
				end
				default: ph = HUNT_HIGH;
			endcase
		endfunction

		function void check_beat(logic [15:0] tdata, logic tlast);
			body_beat_t e;
			if (expected_beats.size() == 0) begin
				$display("%0t: unexpected beat: expected none, got byte %02h pos %0d last %0d",
					$time, tdata[7:0], tdata[13:8], tlast);
				errors++;
			end else begin
				e = expected_beats.pop_front();
				if (tdata[7:0] !== e.data || tdata[13:8] !== e.pos || tlast !== e.is_last) begin
					$display("%0t: beat mismatch: expected byte %02h pos %0d last %0d, got byte %02h pos %0d last %0d",
						$time, e.data, e.pos, e.is_last, tdata[7:0], tdata[13:8], tlast);
					errors++;
				end
			end
		endfunction

		function void check_drained();
			body_beat_t e;
			while (expected_beats.size() != 0) begin
				e = expected_beats.pop_front();
				$display("%0t: missing beat: expected byte %02h pos %0d last %0d, got none",
					$time, e.data, e.pos, e.is_last);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [7:0]  cfg_index;
	logic [7:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] rx_byte
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // [7:0] body_byte, [13:8] body_position, [15:14] zero
	logic        m_tlast;   // body_last

	frame_scoreboard sb;
	bit idle_on;
	bit hold_req;
	int sent_count;

	serial_frame_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT);
		$display("serial_frame_parser_tb: FAIL");
		$finish;
	end

	// receiver: random stalls, plus one long hold-off when asked
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) sb.check_beat(m_tdata, m_tlast);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				m_tready <= !(idle_on && $urandom_range(99) < 35);
			end
		end
	end

	task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic push_byte(input logic [7:0] b);
		if (idle_on && $urandom_range(99) < 27) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		sb.note_rx_byte(b);
	endtask

	// wait for every queued beat, then let the back end settle
	task automatic drain();
		int n;
		n = 0;
		s_tvalid <= 1'b0;
		while (sb.expected_beats.size() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_body_byte();
		int s;
		s = $urandom_range(99);
		if (s < 10) return 8'h00;
		if (s < 20) return 8'hFF;
		return 8'($urandom_range(255));
	endfunction

	function automatic int pick_len();
		int s;
		s = $urandom_range(99);
		if (s < 6) return MAX_BODY - 1;
		if (s < 20) return $urandom_range(9, MAX_BODY - 2);
		return $urandom_range(1, 8);
	endfunction

	task automatic send_frame(input int len, input bit good_sum);
		logic [7:0] sum;
		logic [7:0] b;
		sum = 8'h00;
		push_byte(sb.sync_high);
		push_byte(sb.sync_low);
		push_byte(8'(len));
		for (int i = 0; i < len; i++) begin
			b = pick_body_byte();
			sum = sum + b;
			push_byte(b);
		end
		if (good_sum) push_byte(sum);
		else push_byte(sum ^ 8'($urandom_range(1, 255)));
		sent_count += len + 4;
	endtask

	task automatic send_bad_sync();
		logic [7:0] b;
		push_byte(sb.sync_high);
		if (sb.sync_high != sb.sync_low && $urandom_range(1) == 1) begin
			b = sb.sync_high;
		end else begin
			b = 8'($urandom_range(255));
			while (b == sb.sync_low) b = 8'($urandom_range(255));
		end
		push_byte(b);
		sent_count += 2;
	endtask

	task automatic send_bad_len();
		push_byte(sb.sync_high);
		push_byte(sb.sync_low);
		if ($urandom_range(1) == 0) push_byte(8'h00);
		else push_byte(8'($urandom_range(MAX_BODY, 255)));
		sent_count += 3;
	endtask

	// noise on the line; mostly steers clear of the first sync byte
	task automatic send_noise();
		logic [7:0] b;
		repeat ($urandom_range(1, 4)) begin
			b = 8'($urandom_range(255));
			if (b == sb.sync_high && $urandom_range(9) != 0) b = ~b;
			push_byte(b);
			sent_count++;
		end
	endtask

	task automatic run_random_phase(input bit want_max);
		int frames;
		int r;
		frames     = 0;
		sent_count = 0;
		while (sent_count < PHASE_ITEMS) begin
			r = $urandom_range(99);
			if (r < 70) begin
				send_frame((want_max && frames == 0) ? MAX_BODY - 1 : pick_len(), 1'b1);
				frames++;
			end else if (r < 78) begin
				send_frame(pick_len(), 1'b0);
			end else if (r < 84) begin
				send_bad_sync();
			end else if (r < 90) begin
				send_bad_len();
			end else begin
				send_noise();
			end
		end
	endtask

	initial begin
		logic [7:0] v;
		sb        = new();
		idle_on   = 1'b1;
		hold_req  = 1'b0;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= 8'h00;
		cfg_data  <= 8'h00;
		s_tvalid  <= 1'b0;
		s_tdata   <= 8'h00;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// writes to unmapped indexes must leave the sync bytes alone
		write_reg(REG_UNUSED_LO, 8'h00);
		write_reg(REG_UNUSED_HI, 8'hFF);

		// shortest frame, all-zero body and checksum
		push_byte(SYNC_HIGH_RST); push_byte(SYNC_LOW_RST);
		push_byte(8'd1); push_byte(8'h00); push_byte(8'h00);
		// bad second sync byte equal to the first: no resync on it
		push_byte(SYNC_HIGH_RST); push_byte(SYNC_HIGH_RST); push_byte(SYNC_LOW_RST);
		// zero length, then lengths past the buffer
		push_byte(SYNC_HIGH_RST); push_byte(SYNC_LOW_RST); push_byte(8'd0);
		push_byte(SYNC_HIGH_RST); push_byte(SYNC_LOW_RST); push_byte(8'd64);
		push_byte(SYNC_HIGH_RST); push_byte(SYNC_LOW_RST); push_byte(8'hFF);
		// checksum mismatch: dropped
		push_byte(SYNC_HIGH_RST); push_byte(SYNC_LOW_RST); push_byte(8'd2);
		push_byte(8'hFF); push_byte(8'h01); push_byte(8'h01);
		// sum wraps past 8 bits
		push_byte(SYNC_HIGH_RST); push_byte(SYNC_LOW_RST); push_byte(8'd2);
		push_byte(8'hFF); push_byte(8'hFF); push_byte(8'hFE);
		drain();

		write_reg(REG_SYNC_HIGH, 8'h00);
		write_reg(REG_SYNC_LOW, 8'hFF);
		run_random_phase(1'b1);
		drain();

		// no idling on either side; the receiver holds off once, so the banks can fill
		write_reg(REG_SYNC_HIGH, 8'hFF);
		write_reg(REG_SYNC_LOW, 8'h00);
		idle_on  = 1'b0;
		hold_req = 1'b1;
		run_random_phase(1'b0);
		drain();
		idle_on = 1'b1;

		write_reg(REG_SYNC_HIGH, 8'($urandom_range(255)));
		write_reg(REG_SYNC_LOW, 8'($urandom_range(255)));
		run_random_phase(1'b1);
		drain();

		// identical sync bytes
		v = 8'($urandom_range(255));
		write_reg(REG_SYNC_HIGH, v);
		write_reg(REG_SYNC_LOW, v);
		run_random_phase(1'b0);
		drain();

		sb.check_drained();
		if (sb.errors == 0) begin
			$display("serial_frame_parser_tb: PASS");
		end else begin
			$display("serial_frame_parser_tb: FAIL");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/sfp_pkg.sv
sv/sfp_ram.sv
sv/sfp_front.sv
sv/sfp_queue.sv
sv/sfp_back.sv
sv/serial_frame_parser.sv
sv/sfp_checker.sv
sim/serial_frame_parser_tb.sv
